/* rtl/lrc_frame_receive_parser_macros.svh */
// -----------------------------------------------------------------------------
// lrc_frame_receive_parser_macros.svh
// Assertion helpers shared by the receive parser RTL.
// -----------------------------------------------------------------------------
`ifndef LRC_FRAME_RECEIVE_PARSER_MACROS_SVH
`define LRC_FRAME_RECEIVE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lrc_rx_pkg.sv */
// -----------------------------------------------------------------------------
// lrc_rx_pkg
// Types and codes for the serial frame receive parser.
// -----------------------------------------------------------------------------
package lrc_rx_pkg;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SLOT   = 3'd1,
        PH_CTRL   = 3'd2,
        PH_NAKCHK = 3'd3,
        PH_HEADER = 3'd4,
        PH_BODY   = 3'd5,
        PH_LRC    = 3'd6
    } phase_t;

    // event_kind codes
    localparam logic [2:0] EV_FRAME_BYTE = 3'd0;
    localparam logic [2:0] EV_FRAME_DONE = 3'd1;
    localparam logic [2:0] EV_NAK        = 3'd2;
    localparam logic [2:0] EV_ERROR      = 3'd3;
    localparam logic [2:0] EV_CARD_OUT   = 3'd4;
    localparam logic [2:0] EV_CARD_IN    = 3'd5;
    localparam logic [2:0] EV_CARD_UNK   = 3'd6;
    localparam logic [2:0] EV_TIME_REQ   = 3'd7;

    // error_cause codes
    localparam logic [1:0] ERR_LEAD    = 2'd0;
    localparam logic [1:0] ERR_CTRL    = 2'd1;
    localparam logic [1:0] ERR_NAK_CHK = 2'd2;
    localparam logic [1:0] ERR_LENGTH  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd0;
    localparam logic [1:0] CFG_ECHO_SKIP     = 2'd1;

    // protocol bytes
    localparam logic [7:0] BYTE_STX       = 8'h03;
    localparam logic [7:0] BYTE_ACK       = 8'h06;
    localparam logic [7:0] BYTE_NAK       = 8'h15;
    localparam logic [7:0] BYTE_NAK_CHK   = BYTE_STX ^ BYTE_NAK;
    localparam logic [7:0] BYTE_MOVE      = 8'h50;
    localparam logic [7:0] BYTE_CARD_OUT  = 8'h02;
    localparam logic [7:0] BYTE_CARD_IN   = 8'h03;
    localparam logic [7:0] LRC_EXPECT     = BYTE_STX ^ BYTE_ACK;

    localparam logic [15:0] HDR_LAST_POS  = 16'd4;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd10;

    localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd271;
    localparam logic        ECHO_SKIP_RESET     = 1'b1;

endpackage

/* rtl/lrc_frame_receive_parser.sv */
// -----------------------------------------------------------------------------
// lrc_frame_receive_parser
// Parses reader-to-host serial frames from a byte stream into events.
// -----------------------------------------------------------------------------
// Usage:
//   s_* channel: one received serial byte per transaction (s_rx_byte).
//   m_* channel: at most one event per input byte: frame bytes with their
//     index, frame done with length and LRC verdict, NAK, errors, card
//     movement and time requests.
//   cfg_* channel: register writes (0 = max_frame_length, 1 = echo_skip),
//     always ready; write only while no byte is in flight. Other indexes
//     are dropped.
// A taken byte is held in the input register; its event is then registered in the result register and shown on m_*.
// Throughput: one byte per cycle; the input register and the result register
//   both advance whenever the result register is empty or being taken.
// Stall: with a result held and m_ready low, s_ready is low as soon as the
//   input register holds a byte (an empty one takes one more byte first);
//   s_ready follows m_ready in the same cycle. Nothing is lost.
// Reset (aresetn low, synchronous): hunting for a lead byte, both stages
//   empty, registers at defaults (271, echo skip on), echo pending set.
// -----------------------------------------------------------------------------
module lrc_frame_receive_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_frame_byte,
    output logic [15:0] m_byte_index,
    output logic [15:0] m_frame_length,
    output logic        m_lrc_good,
    output logic [1:0]  m_error_cause,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lrc_rx_pkg::*;

    // largest total the length field may encode
    localparam logic [16:0] LEN_CAP = 17'((64'd1 << LENGTH_BITS) - 64'd1);

    // configuration
    logic [15:0] max_frame_len_reg;
    logic        echo_skip_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [7:0]             lrc_reg, lrc_next;
    logic [15:0]            count_reg, count_next;
    logic [15:0]            len_lo_reg, len_lo_next;   // length bytes 1,2
    logic                   len_hi_reg, len_hi_next;   // length byte 3 nonzero
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic                   echo_reg, echo_next;

    // result register
    logic        m_valid_reg;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  fbyte_reg, fbyte_next;
    logic [15:0] index_reg, index_next;
    logic [15:0] flen_reg, flen_next;
    logic        good_reg, good_next;
    logic [1:0]  cause_reg, cause_next;
    logic        emit;

    logic        advance;
    logic        work;
    logic [7:0]  b;
    logic [15:0] count_inc;
    logic [16:0] total_calc;
    logic [16:0] limit;
    logic        len_bad;
    logic        body_done;

    assign advance   = !m_valid_reg || m_ready;
    assign work      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign b         = in_byte_reg;
    assign count_inc = count_reg + 16'd1;

    // length check at the last header byte; byte 4 holds bits 31:24 and must be zero
    assign total_calc = FRAME_OVERHEAD + {1'b0, len_lo_reg};
    assign limit      = ({1'b0, max_frame_len_reg} > LEN_CAP) ? LEN_CAP
                                                              : {1'b0, max_frame_len_reg};
    assign len_bad    = len_hi_reg || (b != 8'h00) || (total_calc > limit);
    assign body_done  = count_inc >= 16'(total_reg);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT: begin
                if (b == BYTE_MOVE) begin
                    phase_next = PH_SLOT;
                end else if (b == BYTE_STX) begin
                    phase_next = PH_CTRL;
                end
            end
            PH_SLOT:   phase_next = PH_HUNT;
            PH_CTRL: begin
                if (b == BYTE_ACK) begin
                    phase_next = PH_HEADER;
                end else if (b == BYTE_NAK) begin
                    phase_next = PH_NAKCHK;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_NAKCHK: phase_next = PH_HUNT;
            PH_HEADER: begin
                if (count_reg == HDR_LAST_POS) begin
                    phase_next = len_bad ? PH_HUNT : PH_BODY;
                end
            end
            PH_BODY: begin
                if (body_done) begin
                    phase_next = PH_LRC;
                end
            end
            PH_LRC:    phase_next = PH_HUNT;
            default:   phase_next = PH_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        lrc_next    = lrc_reg;
        count_next  = count_reg;
        len_lo_next = len_lo_reg;
        len_hi_next = len_hi_reg;
        total_next  = total_reg;
        echo_next   = echo_reg;
        emit        = 1'b0;
        kind_next   = EV_FRAME_BYTE;
        fbyte_next  = 8'h00;
        index_next  = 16'h0000;
        flen_next   = 16'h0000;
        good_next   = 1'b0;
        cause_next  = ERR_LEAD;

        unique case (phase_reg)
            PH_HUNT: begin
                if (b != BYTE_MOVE && b != BYTE_STX) begin
                    emit = 1'b1;
                    if (b[7]) begin
                        kind_next = EV_TIME_REQ;
                    end else begin
                        kind_next  = EV_ERROR;
                        cause_next = ERR_LEAD;
                        echo_next  = echo_skip_reg;
                    end
                end
            end
            PH_SLOT: begin
                emit = 1'b1;
                if (b == BYTE_CARD_OUT) begin
                    kind_next = EV_CARD_OUT;
                end else if (b == BYTE_CARD_IN) begin
                    kind_next = EV_CARD_IN;
                end else begin
                    kind_next = EV_CARD_UNK;
                end
            end
            PH_CTRL: begin
                if (b == BYTE_ACK) begin
                    lrc_next    = 8'h00;
                    count_next  = 16'h0000;
                    len_lo_next = 16'h0000;
                    len_hi_next = 1'b0;
                    total_next  = '0;
                end else if (b != BYTE_NAK) begin
                    emit       = 1'b1;
                    kind_next  = EV_ERROR;
                    cause_next = ERR_CTRL;
                    echo_next  = echo_skip_reg;
                end
            end
            PH_NAKCHK: begin
                emit      = 1'b1;
                echo_next = echo_skip_reg;
                if (b == BYTE_NAK_CHK) begin
                    kind_next = EV_NAK;
                end else begin
                    kind_next  = EV_ERROR;
                    cause_next = ERR_NAK_CHK;
                end
            end
            PH_HEADER: begin
                lrc_next   = lrc_reg ^ b;
                count_next = count_inc;
                emit       = !echo_reg;
                fbyte_next = b;
                index_next = count_reg;
                if (count_reg == 16'd1) begin
                    len_lo_next[7:0] = b;
                end
                if (count_reg == 16'd2) begin
                    len_lo_next[15:8] = b;
                end
                if (count_reg == 16'd3) begin
                    len_hi_next = (b != 8'h00);
                end
                if (count_reg == HDR_LAST_POS) begin
                    if (len_bad) begin
                        // error replaces the frame byte event
                        emit       = 1'b1;
                        kind_next  = EV_ERROR;
                        cause_next = ERR_LENGTH;
                        fbyte_next = 8'h00;
                        index_next = 16'h0000;
                        echo_next  = echo_skip_reg;
                    end else begin
                        total_next = total_calc[LENGTH_BITS-1:0];
                    end
                end
            end
            PH_BODY: begin
                lrc_next   = lrc_reg ^ b;
                count_next = count_inc;
                emit       = !echo_reg;
                fbyte_next = b;
                index_next = count_reg;
            end
            PH_LRC: begin
                if (echo_reg) begin
                    echo_next = 1'b0;      // echo frame swallowed
                end else begin
                    emit      = 1'b1;
                    kind_next = EV_FRAME_DONE;
                    flen_next = 16'(total_reg);
                    good_next = ((lrc_reg ^ b) == LRC_EXPECT);
                    echo_next = echo_skip_reg;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_len_reg <= MAX_FRAME_LEN_RESET;
            echo_skip_reg     <= ECHO_SKIP_RESET;
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            phase_reg         <= PH_HUNT;
            lrc_reg           <= 8'h00;
            count_reg         <= 16'h0000;
            len_lo_reg        <= 16'h0000;
            len_hi_reg        <= 1'b0;
            total_reg         <= '0;
            echo_reg          <= ECHO_SKIP_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_FRAME_LEN) begin
                    max_frame_len_reg <= cfg_data;
                end else if (cfg_index == CFG_ECHO_SKIP) begin
                    echo_skip_reg <= cfg_data[0];
                end
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= work && emit;
            end
            if (work) begin
                phase_reg  <= phase_next;
                lrc_reg    <= lrc_next;
                count_reg  <= count_next;
                len_lo_reg <= len_lo_next;
                len_hi_reg <= len_hi_next;
                total_reg  <= total_next;
                echo_reg   <= echo_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (work && emit) begin
            kind_reg  <= kind_next;
            fbyte_reg <= fbyte_next;
            index_reg <= index_next;
            flen_reg  <= flen_next;
            good_reg  <= good_next;
            cause_reg <= cause_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = kind_reg;
    assign m_frame_byte   = fbyte_reg;
    assign m_byte_index   = index_reg;
    assign m_frame_length = flen_reg;
    assign m_lrc_good     = good_reg;
    assign m_error_cause  = cause_reg;

    `include "lrc_frame_receive_parser_macros.svh"

    `LRC_ASSERT_IMPL(a_body_below_total, aclk, aresetn,
        phase_reg == PH_BODY,
        (count_reg < 16'(total_reg)) && (count_reg > HDR_LAST_POS),
        "body count outside frame")
    `LRC_ASSERT_IMPL(a_lrc_at_total, aclk, aresetn,
        phase_reg == PH_LRC, count_reg == 16'(total_reg),
        "check byte phase with short count")
    `LRC_ASSERT_IMPL(a_done_min_length, aclk, aresetn,
        m_valid_reg && (kind_reg == EV_FRAME_DONE), flen_reg >= 16'd10,
        "frame done shorter than header")
    `LRC_ASSERT_IMPL(a_nonbyte_fields_zero, aclk, aresetn,
        m_valid_reg && (kind_reg != EV_FRAME_BYTE),
        (fbyte_reg == 8'h00) && (index_reg == 16'h0000),
        "byte fields set on non-byte event")
    `LRC_ASSERT_NEXT(a_ack_opens_header, aclk, aresetn,
        work && (phase_reg == PH_CTRL) && (in_byte_reg == BYTE_ACK),
        (phase_reg == PH_HEADER) && (count_reg == 16'h0000) && (lrc_reg == 8'h00),
        "ACK did not open header")

endmodule

/* tb/sv/lrc_rx_event_tracker_pkg.sv */
// -----------------------------------------------------------------------------
// lrc_rx_event_tracker_pkg
// Tracks the events the receive parser should emit and checks the actual ones.
// -----------------------------------------------------------------------------
package lrc_rx_event_tracker_pkg;

    import lrc_rx_pkg::*;

    // bytes at or above this are time requests while hunting
    localparam logic [7:0] TIME_REQ_MIN = 8'h80;
    // error_cause and other unused fields read zero outside their kind
    localparam logic [1:0] NO_CAUSE     = 2'd0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] pos;
        logic [15:0] flen;
        logic        good;
        logic [1:0]  cause;
    } rx_event_t;

    class rx_event_tracker;
        int unsigned  length_bits;

        // register copies
        logic [15:0]  max_len;
        logic         echo_skip;

        // parser state
        phase_t       ph;
        logic [7:0]   lrc;
        logic [15:0]  count;
        logic [31:0]  len_acc;
        logic [15:0]  total_len;
        logic         echo_pending;

        rx_event_t    pending_events[$];
        int unsigned  mismatches;

        function new(int unsigned bits);
            length_bits  = bits;
            mismatches   = 0;
            max_len      = MAX_FRAME_LEN_RESET;
            echo_skip    = ECHO_SKIP_RESET;
            ph           = PH_HUNT;
            lrc          = '0;
            count        = '0;
            len_acc      = '0;
            total_len    = '0;
            echo_pending = ECHO_SKIP_RESET;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_MAX_FRAME_LEN: max_len = value;
                CFG_ECHO_SKIP:     echo_skip = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned waiting();
            return pending_events.size();
        endfunction

        function void push(logic [2:0] kind, logic [7:0] data, logic [15:0] pos,
                           logic [15:0] flen, logic good, logic [1:0] cause);
            rx_event_t ev;
            ev = '{kind, data, pos, flen, good, cause};
            pending_events.push_back(ev);
        endfunction

        // frame done, nak and error: back to hunting, echo flag reloads
        function void finish(logic [2:0] kind, logic [15:0] flen, logic good,
                             logic [1:0] cause);
            ph           = PH_HUNT;
            echo_pending = echo_skip;
            push(kind, 8'd0, 16'd0, flen, good, cause);
        endfunction

        function void stream_byte(logic [7:0] b);
            logic [15:0] pos;
            pos   = count;
            lrc   = lrc ^ b;
            count = count + 16'd1;
            if (!echo_pending)
                push(EV_FRAME_BYTE, b, pos, 16'd0, 1'b0, NO_CAUSE);
        endfunction

        // one accepted byte
        function void take_byte(logic [7:0] b);
            logic [15:0] pos;
            logic [33:0] total;
            logic [33:0] lim;
            case (ph)
                PH_HUNT: begin
                    if (b == BYTE_MOVE)
                        ph = PH_SLOT;
                    else if (b == BYTE_STX)
                        ph = PH_CTRL;
                    else if (b >= TIME_REQ_MIN)
                        push(EV_TIME_REQ, 8'd0, 16'd0, 16'd0, 1'b0, NO_CAUSE);
                    else
                        finish(EV_ERROR, 16'd0, 1'b0, ERR_LEAD);
                end
                PH_SLOT: begin
                    ph = PH_HUNT;
                    if (b == BYTE_CARD_OUT)
                        push(EV_CARD_OUT, 8'd0, 16'd0, 16'd0, 1'b0, NO_CAUSE);
                    else if (b == BYTE_CARD_IN)
                        push(EV_CARD_IN, 8'd0, 16'd0, 16'd0, 1'b0, NO_CAUSE);
                    else
                        push(EV_CARD_UNK, 8'd0, 16'd0, 16'd0, 1'b0, NO_CAUSE);
                end
                PH_CTRL: begin
                    if (b == BYTE_ACK) begin
                        ph        = PH_HEADER;
                        lrc       = '0;
                        count     = '0;
                        len_acc   = '0;
                        total_len = '0;
                    end else if (b == BYTE_NAK) begin
                        ph = PH_NAKCHK;
                    end else begin
                        finish(EV_ERROR, 16'd0, 1'b0, ERR_CTRL);
                    end
                end
                PH_NAKCHK: begin
                    if (b == BYTE_NAK_CHK)
                        finish(EV_NAK, 16'd0, 1'b0, NO_CAUSE);
                    else
                        finish(EV_ERROR, 16'd0, 1'b0, ERR_NAK_CHK);
                end
                PH_HEADER: begin
                    pos = count;
                    if (pos >= 16'd1 && pos <= HDR_LAST_POS)
                        len_acc = len_acc | (32'(b) << (8 * (pos - 16'd1)));
                    total = 34'(len_acc) + 34'(FRAME_OVERHEAD);
                    lim   = (34'd1 << length_bits) - 34'd1;
                    if (34'(max_len) < lim)
                        lim = 34'(max_len);
                    if (pos >= HDR_LAST_POS && total > lim) begin
                        finish(EV_ERROR, 16'd0, 1'b0, ERR_LENGTH);
                    end else begin
                        stream_byte(b);
                        if (pos >= HDR_LAST_POS) begin
                            total_len = total[15:0];
                            ph        = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    stream_byte(b);
                    if (count >= total_len)
                        ph = PH_LRC;
                end
                PH_LRC: begin
                    // an echoed frame ends silently
                    if (echo_pending) begin
                        echo_pending = 1'b0;
                        ph           = PH_HUNT;
                    end else begin
                        finish(EV_FRAME_DONE, total_len, (lrc ^ b) == LRC_EXPECT, NO_CAUSE);
                    end
                end
                default: ph = PH_HUNT;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // one accepted result against the oldest expected event
        function void match_event(rx_event_t got);
            rx_event_t want;
            if (pending_events.size() == 0) begin
                $error("event_kind: expected none, got 0x%0h", got.kind);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", want.kind, got.kind);
            compare_field("frame_byte", want.data, got.data);
            compare_field("byte_index", want.pos, got.pos);
            compare_field("frame_length", want.flen, got.flen);
            compare_field("lrc_good", want.good, got.good);
            compare_field("error_cause", want.cause, got.cause);
        endfunction
    endclass

endpackage

/* tb/sv/tb_lrc_frame_receive_parser.sv */
// -----------------------------------------------------------------------------
// tb_lrc_frame_receive_parser
// Self-checking bench for the serial frame receive parser: a short directed
// sequence, then phases of random frames and noise under several register
// settings and handshake idling patterns, checked event by event.
// -----------------------------------------------------------------------------
module tb_lrc_frame_receive_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import lrc_rx_pkg::*;
    import lrc_rx_event_tracker_pkg::*;

    localparam int LEN_BITS = 16;

    // indexes past the register list; writes there must be dropped
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_kind;
    logic [7:0]  m_frame_byte;
    logic [15:0] m_byte_index;
    logic [15:0] m_frame_length;
    logic        m_lrc_good;
    logic [1:0]  m_error_cause;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    // idling knobs, percent per cycle
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned bytes_sent = 0;
    bit          spare_toggle = 1'b0;

    rx_event_tracker tracker;

    lrc_frame_receive_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_frame_byte  (m_frame_byte),
        .m_byte_index  (m_byte_index),
        .m_frame_length(m_frame_length),
        .m_lrc_good    (m_lrc_good),
        .m_error_cause (m_error_cause),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver side: m_ready re-rolled every cycle, one NBA per edge.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: both channels sampled at the edge, pre-update values.
    // Input transaction is noted before the result check, so ordering
    // against the driver process never matters.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_byte(s_rx_byte);
            if (m_valid && m_ready)
                tracker.match_event('{m_event_kind, m_frame_byte, m_byte_index,
                                      m_frame_length, m_lrc_good, m_error_cause});
        end
    end

    // One byte transaction. Valid stays high across back-to-back bytes;
    // a random gap drops it first.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, value);
    endtask

    // Both registers, plus a write to a spare index that must be ignored.
    // Only called with the parser idle.
    task automatic configure(input logic [15:0] max_len, input logic echo);
        cfg_write(CFG_MAX_FRAME_LEN, max_len);
        cfg_write(CFG_ECHO_SKIP, {15'd0, echo});
        cfg_write(spare_toggle ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
        spare_toggle = !spare_toggle;
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected event, then keep the clock running: an echoed or
    // silent byte may still sit in the pipeline with nothing expected.
    task automatic settle();
        @(posedge aclk);
        while (tracker.waiting() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ACK frame: STX, ACK, 5-byte header with little-endian length in
    // bytes 1..4, body, check byte. Stops after the header when the length
    // is out of range, since the parser drops back to hunting there.
    task automatic send_ack_frame(input logic [31:0] plen, input bit lrc_ok);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [33:0] total;
        logic [33:0] lim;
        int unsigned i;
        total = 34'(plen) + 34'(FRAME_OVERHEAD);
        lim   = (34'd1 << LEN_BITS) - 34'd1;
        if (34'(tracker.max_len) < lim)
            lim = 34'(tracker.max_len);
        send_byte(BYTE_STX);
        send_byte(BYTE_ACK);
        b   = 8'($urandom_range(0, 255));
        sum = b;
        send_byte(b);
        for (i = 0; i < 4; i++) begin
            b   = plen[8*i +: 8];
            sum = sum ^ b;
            send_byte(b);
        end
        if (total > lim)
            return;
        // header is 5 of the total bytes
        for (i = 0; i < total - 5; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            send_byte(b);
        end
        send_byte(lrc_ok ? (sum ^ LRC_EXPECT) : 8'($urandom_range(0, 255)));
    endtask

    // One random unit: mostly ACK frames (some too long or with a bad check byte),
    // the rest NAK frames, card movement, time requests, broken control bytes and raw noise.
    task automatic send_random_unit();
        int unsigned pick;
        int unsigned q;
        int unsigned room;
        logic [31:0] plen;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 55) begin
            q = $urandom_range(99);
            if (tracker.max_len >= 16'd10) begin
                room = tracker.max_len - 10;
                if (q < 75)
                    plen = $urandom_range(0, (room < 24) ? room : 24);
                else if (q < 78 && room <= 300)
                    plen = room;                        // frame right at the limit
                else if (q < 92)
                    plen = room + 1 + $urandom_range(0, 3);  // just over the limit
                else
                    plen = $urandom();                  // wild length, high bytes set
            end else begin
                // limit below the overhead: every frame is too long
                plen = (q < 50) ? $urandom_range(0, 8) : $urandom();
            end
            send_ack_frame(plen, $urandom_range(99) < 75);
        end else if (pick < 63) begin
            send_byte(BYTE_STX);
            send_byte(BYTE_NAK);
            send_byte(($urandom_range(99) < 75) ? BYTE_NAK_CHK : 8'($urandom_range(0, 255)));
        end else if (pick < 71) begin
            q = $urandom_range(2);
            b = (q == 0) ? BYTE_CARD_OUT : (q == 1) ? BYTE_CARD_IN : 8'($urandom_range(0, 255));
            send_byte(BYTE_MOVE);
            send_byte(b);
        end else if (pick < 79) begin
            send_byte(8'($urandom_range(128, 255)));
        end else if (pick < 87) begin
            send_byte(BYTE_STX);
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Random phase under one register setting and one idling pattern.
    // Ends with the sender paused until every event has come back.
    task automatic run_phase(input logic [15:0] max_len, input logic echo,
                             input int unsigned in_pct, input int unsigned out_pct,
                             input int unsigned n_bytes);
        int unsigned target;
        configure(max_len, echo);
        idle_pct  = in_pct;
        stall_pct = out_pct;
        target    = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_random_unit();
        s_valid <= 1'b0;
        settle();
    endtask

    // Main sequence
    initial begin
        tracker = new(LEN_BITS);

        // synchronous reset
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, no idling ----
        // echo skip off: once the first terminal event reloads the flag,
        // the directed ACK frame is reported in full
        configure(16'd271, 1'b0);
        send_byte(8'h00);                        // bad lead byte, lowest value
        send_byte(8'h80);                        // time request, lowest
        send_byte(8'hFF);                        // time request, highest
        send_byte(BYTE_MOVE); send_byte(BYTE_CARD_OUT);
        send_byte(BYTE_MOVE); send_byte(BYTE_CARD_IN);
        send_byte(BYTE_MOVE); send_byte(8'hA5);  // unknown movement
        send_byte(BYTE_STX); send_byte(BYTE_NAK); send_byte(BYTE_NAK_CHK);
        send_byte(BYTE_STX); send_byte(BYTE_NAK); send_byte(8'h00);  // bad nak check
        send_byte(BYTE_STX); send_byte(8'h44);   // bad control byte
        send_ack_frame(32'd0, 1'b1);             // shortest frame, good LRC
        s_valid <= 1'b0;
        settle();

        // ---- random phases ----
        run_phase(16'd271,   1'b1,  0,  0, 350);  // reset values, no idling
        run_phase(16'd10,    1'b0, 55,  0, 250);  // smallest usable limit
        run_phase(16'd65535, 1'b1,  0, 55, 400);  // largest limit
        run_phase(16'd40,    1'b0, 13, 13, 400);
        run_phase(16'd0,     1'b1, 55,  0, 100);  // limit below overhead
        run_phase(16'd271,   1'b0,  0,  0, 250);

        if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* lrc_frame_receive_parser.f */
+incdir+rtl
rtl/lrc_rx_pkg.sv
rtl/lrc_frame_receive_parser.sv
tb/sv/lrc_rx_event_tracker_pkg.sv
tb/sv/tb_lrc_frame_receive_parser.sv
